/* hw/rtl/frm_pkg.sv */
// Shared types and constants for the per-feature range and mean block.
// Used by frm_mem, frm_divider and feature_range_and_mean; depends on nothing.
`default_nettype none

package frm_pkg;

   // Field widths
   localparam int CFG_W     = 5;
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 32;
   localparam int COUNT_W   = 16;
   localparam int INDEX_W   = 4;
   localparam int STATUS_W  = 2;

   // Defaults and limits
   localparam int DEFAULT_MAX_FEATURES = 16;
   localparam int MAX_SAMPLES          = 65535;
   localparam logic [CFG_W-1:0] FEATURE_COUNT_RESET = 5'd1;

   // Divider: one quotient bit per step
   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MID_SAMPLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED  = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       end_of_set;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]         feature_index;
      logic [SAMPLE_W-1:0]        value_range;
      logic signed [SAMPLE_W-1:0] mean_value;
      logic [STATUS_W-1:0]        status;
      logic                       last_result;
   } rsp_type;

   // One statistics entry per feature
   typedef struct packed {
      logic [SUM_W-1:0]           sum_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [SAMPLE_W-1:0] min_value;
   } entry_type;

endpackage

`default_nettype wire

/* hw/rtl/frm_mem.sv */
// Statistics memory: one entry (sum, maximum, minimum) per feature.
// One write port, one read port with registered data; uses frm_pkg::entry_type.
`default_nettype none

module frm_mem #(
   parameter int DEPTH  = frm_pkg::DEFAULT_MAX_FEATURES,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire frm_pkg::entry_type wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output frm_pkg::entry_type     rd_data
);

   frm_pkg::entry_type mem_ff [DEPTH];
   frm_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/frm_divider.sv */
// Shared sequential divider: signed 32-bit sum by unsigned 16-bit count,
// truncated toward zero, one quotient bit per cycle. Uses frm_pkg constants.
`default_nettype none

module frm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [frm_pkg::SUM_W-1:0]     dividend,
   input  wire logic [frm_pkg::COUNT_W-1:0]   divisor,
   output logic                               busy,
   output logic                               done,
   output logic [frm_pkg::SAMPLE_W-1:0]       quotient
);

   localparam int SW = frm_pkg::SUM_W;
   localparam int CW = frm_pkg::COUNT_W;
   localparam int QW = frm_pkg::SAMPLE_W;
   localparam int TW = frm_pkg::DIV_STEP_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [TW-1:0] step_ff, step_in;
   logic          neg_ff, neg_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] div_ff, div_in;

   logic [CW:0]   shifted;
   logic [CW:0]   trial;

   // One restoring step per cycle; the dividend magnitude shifts out as quotient shifts in
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[SW-1]};
      trial   = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = TW'(frm_pkg::DIV_STEPS - 1);
         neg_in  = dividend[SW-1];
         quo_in  = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[CW]) begin
            rem_in = trial[CW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = shifted[CW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - TW'(1);
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // Apply the sign to the low quotient bits
   assign quotient = neg_ff ? (~quo_ff[QW-1:0] + QW'(1)) : quo_ff[QW-1:0];
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/feature_range_and_mean.sv */
// Per-feature minimum, maximum and mean statistics over a streamed data set.
//
// Use: values enter on the req_ channel (valid/stall), one feature value per
// transfer, in row order; a sample is feature_count consecutive values. The
// csr_ channel (valid/ready) writes feature_count and restarts the set; it is
// taken only while the block is idle. Results leave on the rsp_ channel
// (valid/stall) through an output register.
// Per value: the feature's entry in the statistics memory is read, then written
// back, so the block takes no new value before it is through with the last;
// req_stall is high for one cycle after every transfer but the closing one.
// End of set: after the closing value, each feature passes through fetch,
// start, the shared divider that produces one quotient bit per cycle (32
// steps), and output. A set that ends mid-sample gives one error result
// through the output register, with no division.
// A stalled receiver holds the output register; the sequencer waits for it.
// Reset: synchronous, feature_count returns to 1 and a new set begins.
// The memory needs no clearing pass: the first sample of a set writes every
// entry before it is read.
`default_nettype none

module feature_range_and_mean #(
   parameter int MAX_FEATURES = frm_pkg::DEFAULT_MAX_FEATURES
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Value channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire frm_pkg::req_type           req_payload,
   // Result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output frm_pkg::rsp_type                rsp_payload,
   // Configuration channel
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [frm_pkg::CFG_W-1:0]  csr_data
);

   localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NUM_W = ($clog2(MAX_FEATURES + 1) > frm_pkg::CFG_W) ?
                          $clog2(MAX_FEATURES + 1) : frm_pkg::CFG_W;
   localparam int CW    = frm_pkg::COUNT_W;
   localparam int SW    = frm_pkg::SUM_W;
   localparam int VW    = frm_pkg::SAMPLE_W;
   localparam logic [CW-1:0] SAMPLE_LIMIT = CW'(frm_pkg::MAX_SAMPLES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_FETCH,
      S_START,
      S_DIVIDE,
      S_OUTPUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [frm_pkg::CFG_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]              k_ff, k_in;
   logic [CW-1:0]                 samples_ff, samples_in;
   logic                          first_ff, first_in;
   logic                          ovf_ff, ovf_in;
   logic                          err_ff, err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   frm_pkg::req_type              req_data_ff, req_data_in;
   frm_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [VW-1:0]                 range_ff, range_in;

   logic [NUM_W-1:0]              count_wide;
   logic [NUM_W-1:0]              eff_count;
   logic [IDX_W-1:0]              last_pos;
   logic                          req_xfer;
   logic                          csr_xfer;
   logic                          counted;
   logic                          wrap;
   logic signed [VW-1:0]          sv;
   logic [SW-1:0]                 sv_wide;

   logic                          mem_we;
   frm_pkg::entry_type            mem_wdata;
   frm_pkg::entry_type            mem_rdata;
   logic [IDX_W-1:0]              mem_raddr;

   logic                          div_start;
   logic                          div_busy;
   logic                          div_done;
   logic [VW-1:0]                 div_quotient;

   // Clamp the feature count to 1..MAX_FEATURES
   assign count_wide = NUM_W'(count_ff);
   always_comb begin
      if (count_wide == '0) begin
         eff_count = NUM_W'(1);
      end else if (count_wide > NUM_W'(MAX_FEATURES)) begin
         eff_count = NUM_W'(MAX_FEATURES);
      end else begin
         eff_count = count_wide;
      end
   end
   assign last_pos = IDX_W'(eff_count - NUM_W'(1));

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_xfer  = csr_valid && csr_ready;
   assign req_xfer  = req_valid && !req_stall;

   assign sv        = req_data_ff.sample_value;
   assign sv_wide   = {{(SW - VW){sv[VW-1]}}, sv};
   assign mem_raddr = (state_ff == S_IDLE) ? pos_ff : k_ff;

   // Sequencer: accumulate one value, or walk the features through the divider
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      samples_in   = samples_ff;
      first_in     = first_ff;
      ovf_in       = ovf_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      req_data_in  = req_data_ff;
      rsp_data_in  = rsp_data_ff;
      range_in     = range_ff;
      mem_we       = 1'b0;
      mem_wdata    = mem_rdata;
      div_start    = 1'b0;
      counted      = 1'b1;
      wrap         = 1'b0;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (csr_xfer) begin
               count_in   = csr_data;
               pos_in     = '0;
               k_in       = '0;
               samples_in = '0;
               first_in   = 1'b1;
               ovf_in     = 1'b0;
               err_in     = 1'b0;
            end else if (req_xfer) begin
               req_data_in = req_payload;
               state_in    = S_UPDATE;
            end
         end

         S_UPDATE: begin
            // Fold the value into its feature's entry
            if (first_ff) begin
               mem_we              = 1'b1;
               mem_wdata.sum_value = sv_wide;
               mem_wdata.max_value = sv;
               mem_wdata.min_value = sv;
            end else if (samples_ff >= SAMPLE_LIMIT) begin
               ovf_in  = 1'b1;
               counted = 1'b0;
            end else begin
               mem_we              = 1'b1;
               mem_wdata.sum_value = mem_rdata.sum_value + sv_wide;
               if (sv > mem_rdata.max_value) begin
                  mem_wdata.max_value = sv;
               end
               if (sv < mem_rdata.min_value) begin
                  mem_wdata.min_value = sv;
               end
            end
            // Advance the feature position; count the sample when it wraps
            if (pos_ff == last_pos) begin
               wrap     = 1'b1;
               pos_in   = '0;
               first_in = 1'b0;
               if (counted) begin
                  samples_in = samples_ff + CW'(1);
               end
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
            if (req_data_ff.end_of_set) begin
               k_in = '0;
               if (!wrap || samples_in == '0) begin
                  err_in   = 1'b1;
                  state_in = S_OUTPUT;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FETCH: begin
            state_in = S_START;
         end

         S_START: begin
            div_start = 1'b1;
            range_in  = mem_rdata.max_value - mem_rdata.min_value;
            state_in  = S_DIVIDE;
         end

         S_DIVIDE: begin
            if (div_done) begin
               state_in = S_OUTPUT;
            end
         end

         S_OUTPUT: begin
            // Load the output register when it is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in.feature_index = '0;
                  rsp_data_in.value_range   = '0;
                  rsp_data_in.mean_value    = '0;
                  rsp_data_in.status        = frm_pkg::STATUS_MID_SAMPLE;
                  rsp_data_in.last_result   = 1'b1;
               end else begin
                  rsp_data_in.feature_index = frm_pkg::INDEX_W'(k_ff);
                  rsp_data_in.value_range   = range_ff;
                  rsp_data_in.mean_value    = div_quotient;
                  rsp_data_in.status        = ovf_ff ? frm_pkg::STATUS_SATURATED :
                                                       frm_pkg::STATUS_OK;
                  rsp_data_in.last_result   = (k_ff == last_pos);
               end
               if (err_ff || k_ff == last_pos) begin
                  pos_in     = '0;
                  k_in       = '0;
                  samples_in = '0;
                  first_in   = 1'b1;
                  ovf_in     = 1'b0;
                  err_in     = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_FETCH;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= frm_pkg::FEATURE_COUNT_RESET;
         pos_ff       <= '0;
         k_ff         <= '0;
         samples_ff   <= '0;
         first_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         samples_ff   <= samples_in;
         first_ff     <= first_in;
         ovf_ff       <= ovf_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
      range_ff    <= range_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   frm_mem #(
      .DEPTH  (MAX_FEATURES),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (pos_ff),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   frm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mem_rdata.sum_value),
      .divisor  (samples_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Position stays inside the configured sample width
   a_pos_bound : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= last_pos)
      else $error("feature position beyond configured count");

   // Sample count never passes the saturation limit
   a_samples_bound : assert property (@(posedge clock) disable iff (reset)
      samples_ff <= SAMPLE_LIMIT)
      else $error("sample count beyond limit");

   // Divider starts only when idle and never by zero
   a_div_start : assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!div_busy && samples_ff != '0))
      else $error("divider started while busy or with zero count");

   // A configuration write restarts the set
   a_csr_restart : assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (pos_ff == '0 && samples_ff == '0 && first_ff && !ovf_ff))
      else $error("configuration write did not restart the set");

endmodule

`default_nettype wire
